// ===== hdl/ctmc_pkg.sv =====
// Shared types, constants and helper functions of the circle tile map collision core.
package ctmc_pkg;

  // Field widths of the stream items.
  localparam int POS_W      = 14;
  localparam int TILE_IDX_W = 6;
  localparam int CODE_W     = 8;
  localparam int RADIUS_W   = 10;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 8;

  // Internal widths, sized for the smallest allowed tile (32 Q.4 units).
  localparam int CELL_W = 9;   // tile index of a centre, at most 511
  localparam int MAG_W  = 11;  // distance magnitude inside a tile, at most 1024
  localparam int SQ_W   = 21;  // square of a magnitude
  localparam int D2_W   = 22;  // sum of two squares
  localparam int R2_W   = 20;  // squared radius

  // Reciprocal division of a position by the tile size.
  localparam int RECIP_SH = 24;
  localparam int PROD_W   = 34;

  // Queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Default map geometry.
  localparam int MAP_COLS_DEF    = 64;
  localparam int MAP_ROWS_DEF    = 64;
  localparam int TILE_PIXELS_DEF = 16;

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_RADIUS = 1'b0;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 10'd160;

  // Item kinds.
  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  // Tile characters that mark a solid tile.
  localparam logic [CODE_W-1:0] CODE_ONE   = 8'h31;  // '1'
  localparam logic [CODE_W-1:0] CODE_UC_LO = 8'h47;  // 'G'
  localparam logic [CODE_W-1:0] CODE_UC_HI = 8'h4E;  // 'N'
  localparam logic [CODE_W-1:0] CODE_LC_LO = 8'h68;  // 'h'
  localparam logic [CODE_W-1:0] CODE_LC_HI = 8'h6E;  // 'n'

  // Front end sequencer states.
  typedef enum logic [2:0] {
    F_IDLE,
    F_DIV,
    F_FIX,
    F_SQR,
    F_PUSH
  } front_state_t;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_SCAN,
    B_DRAIN,
    B_OUT
  } back_state_t;

  // One prepared job handed from the front end to the back end.
  typedef struct packed {
    logic                  is_query;
    logic [TILE_IDX_W-1:0] tile_col;
    logic [TILE_IDX_W-1:0] tile_row;
    logic                  solid;
    logic [CELL_W-1:0]     ccol;
    logic [CELL_W-1:0]     crow;
    logic [SQ_W-1:0]       sqx_lo;  // neighbor column to the left
    logic [SQ_W-1:0]       sqx_hi;  // neighbor column to the right
    logic [SQ_W-1:0]       sqy_lo;  // neighbor row above
    logic [SQ_W-1:0]       sqy_hi;  // neighbor row below
    logic [R2_W-1:0]       r2;
  } job_t;

  // Classifies a tile character as solid or open.
  function automatic logic code_is_solid(input logic [CODE_W-1:0] code);
    logic res;
    res = (code == CODE_ONE) ||
          ((code >= CODE_UC_LO) && (code <= CODE_UC_HI)) ||
          ((code >= CODE_LC_LO) && (code <= CODE_LC_HI));
    return res;
  endfunction

endpackage

// ===== hdl/ctmc_ram.sv =====
// Generic simple dual-port RAM with one write port and one registered read port.
module ctmc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/ctmc_front.sv =====
// Front end: accepts items, classifies tile codes and prepares query distances.
module ctmc_front #(
  parameter int MAP_COLS    = ctmc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS    = ctmc_pkg::MAP_ROWS_DEF,
  parameter int TILE_PIXELS = ctmc_pkg::TILE_PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               clearing,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tuser,
  input  logic [ctmc_pkg::IN_DATA_W-1:0]     in_tdata,
  input  logic [ctmc_pkg::RADIUS_W-1:0]      radius,
  output logic                               push_valid,
  input  logic                               push_ready,
  output ctmc_pkg::job_t                     push_job
);

  localparam int TQ    = TILE_PIXELS * 16;
  localparam int RECIP = (1 << ctmc_pkg::RECIP_SH) / TQ;
  localparam logic [ctmc_pkg::PROD_W-1:0] RECIP_L = ctmc_pkg::PROD_W'(RECIP);
  localparam logic [ctmc_pkg::POS_W:0]    TQ_P    = (ctmc_pkg::POS_W + 1)'(TQ);
  localparam logic [ctmc_pkg::MAG_W-1:0]  TQ_M    = ctmc_pkg::MAG_W'(TQ);
  localparam logic [8:0] COLS_L = 9'(MAP_COLS);
  localparam logic [8:0] ROWS_L = 9'(MAP_ROWS);

  ctmc_pkg::front_state_t state_r, state_nxt;
  ctmc_pkg::job_t         job_r, job_nxt;

  logic [ctmc_pkg::POS_W-1:0]  px_r, px_nxt, py_r, py_nxt;
  logic [ctmc_pkg::CELL_W-1:0] qx_r, qx_nxt, qy_r, qy_nxt;
  logic [ctmc_pkg::MAG_W-1:0]  remx_r, remx_nxt, remy_r, remy_nxt;

  logic [ctmc_pkg::TILE_IDX_W-1:0] f_col, f_row;
  logic [ctmc_pkg::CODE_W-1:0]     f_code;
  logic [ctmc_pkg::POS_W-1:0]      f_px, f_py;
  logic                            accept;
  logic                            in_map;
  logic [ctmc_pkg::PROD_W-1:0]     prod_x, prod_y;
  logic [ctmc_pkg::POS_W:0]        base_x, base_y, rem0_x, rem0_y;
  logic [ctmc_pkg::MAG_W-1:0]      magx_hi, magy_hi;

  // Unpack the input transaction.
  assign f_col  = in_tdata[5:0];
  assign f_row  = in_tdata[11:6];
  assign f_code = in_tdata[19:12];
  assign f_px   = in_tdata[33:20];
  assign f_py   = in_tdata[47:34];

  assign in_tready = (state_r == ctmc_pkg::F_IDLE) && !clearing;
  assign accept    = in_tvalid && in_tready;
  assign in_map    = ({3'b0, f_col} < COLS_L) && ({3'b0, f_row} < ROWS_L);

  // Reciprocal products and remainders for the tile index of the centre.
  assign prod_x  = ctmc_pkg::PROD_W'(px_r) * RECIP_L;
  assign prod_y  = ctmc_pkg::PROD_W'(py_r) * RECIP_L;
  assign base_x  = {6'b0, qx_r} * TQ_P;
  assign base_y  = {6'b0, qy_r} * TQ_P;
  assign rem0_x  = {1'b0, px_r} - base_x;
  assign rem0_y  = {1'b0, py_r} - base_y;
  assign magx_hi = TQ_M - remx_r;
  assign magy_hi = TQ_M - remy_r;

  assign push_valid = (state_r == ctmc_pkg::F_PUSH);
  assign push_job   = job_r;

  // Next state and datapath.
  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    px_nxt    = px_r;
    py_nxt    = py_r;
    qx_nxt    = qx_r;
    qy_nxt    = qy_r;
    remx_nxt  = remx_r;
    remy_nxt  = remy_r;
    case (state_r)
      ctmc_pkg::F_IDLE: begin
        if (accept) begin
          job_nxt.tile_col = f_col;
          job_nxt.tile_row = f_row;
          job_nxt.solid    = ctmc_pkg::code_is_solid(f_code);
          px_nxt           = f_px;
          py_nxt           = f_py;
          if (in_tuser == ctmc_pkg::KIND_QUERY) begin
            job_nxt.is_query = 1'b1;
            state_nxt        = ctmc_pkg::F_DIV;
          end else begin
            job_nxt.is_query = 1'b0;
            // A write beyond the map edge is dropped here.
            state_nxt = in_map ? ctmc_pkg::F_PUSH : ctmc_pkg::F_IDLE;
          end
        end
      end
      ctmc_pkg::F_DIV: begin
        qx_nxt    = prod_x[ctmc_pkg::RECIP_SH +: ctmc_pkg::CELL_W];
        qy_nxt    = prod_y[ctmc_pkg::RECIP_SH +: ctmc_pkg::CELL_W];
        state_nxt = ctmc_pkg::F_FIX;
      end
      ctmc_pkg::F_FIX: begin
        // The estimate is at most one low; one compare corrects it.
        if (rem0_x >= TQ_P) begin
          job_nxt.ccol = qx_r + 1'b1;
          remx_nxt     = ctmc_pkg::MAG_W'(rem0_x - TQ_P);
        end else begin
          job_nxt.ccol = qx_r;
          remx_nxt     = ctmc_pkg::MAG_W'(rem0_x);
        end
        if (rem0_y >= TQ_P) begin
          job_nxt.crow = qy_r + 1'b1;
          remy_nxt     = ctmc_pkg::MAG_W'(rem0_y - TQ_P);
        end else begin
          job_nxt.crow = qy_r;
          remy_nxt     = ctmc_pkg::MAG_W'(rem0_y);
        end
        state_nxt = ctmc_pkg::F_SQR;
      end
      ctmc_pkg::F_SQR: begin
        // Squared distances to the near edges of the outer neighbor tiles.
        job_nxt.sqx_lo = ctmc_pkg::SQ_W'(ctmc_pkg::D2_W'(remx_r) * ctmc_pkg::D2_W'(remx_r));
        job_nxt.sqx_hi = ctmc_pkg::SQ_W'(ctmc_pkg::D2_W'(magx_hi) * ctmc_pkg::D2_W'(magx_hi));
        job_nxt.sqy_lo = ctmc_pkg::SQ_W'(ctmc_pkg::D2_W'(remy_r) * ctmc_pkg::D2_W'(remy_r));
        job_nxt.sqy_hi = ctmc_pkg::SQ_W'(ctmc_pkg::D2_W'(magy_hi) * ctmc_pkg::D2_W'(magy_hi));
        job_nxt.r2     = ctmc_pkg::R2_W'(radius) * ctmc_pkg::R2_W'(radius);
        state_nxt      = ctmc_pkg::F_PUSH;
      end
      ctmc_pkg::F_PUSH: begin
        if (push_ready) begin
          state_nxt = ctmc_pkg::F_IDLE;
        end
      end
      default: begin
        state_nxt = ctmc_pkg::F_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ctmc_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    job_r  <= job_nxt;
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    qx_r   <= qx_nxt;
    qy_r   <= qy_nxt;
    remx_r <= remx_nxt;
    remy_r <= remy_nxt;
  end

endmodule

// ===== hdl/ctmc_queue.sv =====
// Short job queue between the front end and the back end.
module ctmc_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  ctmc_pkg::job_t push_job,
  output logic           pop_valid,
  input  logic           pop_ready,
  output ctmc_pkg::job_t pop_job
);

  localparam int DEPTH = ctmc_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
  localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(DEPTH - 1);

  ctmc_pkg::job_t   mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign push_ready = (count_r != DEPTH_C);
  assign pop_valid  = (count_r != '0);
  assign pop_job    = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Pointer and fill level update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_P) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_P) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

// ===== hdl/ctmc_back.sv =====
// Back end: clears and updates the solidity map and scans the 3x3 neighborhood of a query.
module ctmc_back #(
  parameter int MAP_COLS = ctmc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS = ctmc_pkg::MAP_ROWS_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  output logic           clearing,
  input  logic           pop_valid,
  output logic           pop_ready,
  input  ctmc_pkg::job_t pop_job,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           out_hit
);

  localparam int COL_W = $clog2(MAP_COLS);
  localparam int ROW_W = $clog2(MAP_ROWS);
  localparam int AW    = COL_W + ROW_W;
  localparam int DEPTH = MAP_ROWS * (1 << COL_W);
  localparam int CP_W  = ctmc_pkg::CELL_W + 1;
  localparam logic [AW-1:0]   CLR_LAST = AW'(DEPTH - 1);
  localparam logic [CP_W-1:0] COLS_C   = CP_W'(MAP_COLS);
  localparam logic [CP_W-1:0] ROWS_C   = CP_W'(MAP_ROWS);

  ctmc_pkg::back_state_t state_r, state_nxt;
  ctmc_pkg::job_t        job_r, job_nxt;

  logic [AW-1:0]                clr_cnt_r, clr_cnt_nxt;
  logic [1:0]                   ci_r, ci_nxt, ri_r, ri_nxt;
  logic                         ev_valid_r, ev_valid_nxt;
  logic                         ev_inmap_r, ev_inmap_nxt;
  logic [ctmc_pkg::D2_W-1:0]    ev_d2_r, ev_d2_nxt;
  logic                         hit_acc_r, hit_acc_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_hit_r, out_hit_nxt;

  logic                         ram_we;
  logic [AW-1:0]                ram_wr_addr;
  logic                         ram_wr_data;
  logic [AW-1:0]                ram_rd_addr;
  logic                         ram_rd_data;

  logic [CP_W-1:0]              colp, rowp, col_m1, row_m1;
  logic                         col_ok, row_ok;
  logic [ctmc_pkg::SQ_W-1:0]    sel_dx2, sel_dy2;
  logic                         ev_hit;

  // Map storage, one bit per tile.
  ctmc_ram #(
    .WIDTH (1),
    .DEPTH (DEPTH)
  ) u_map (
    .clk     (clk),
    .we      (ram_we),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // Neighbor position, offset by one so that the left and upper edge stay unsigned.
  assign colp   = {1'b0, job_r.ccol} + CP_W'(ci_r);
  assign rowp   = {1'b0, job_r.crow} + CP_W'(ri_r);
  assign col_m1 = colp - 1'b1;
  assign row_m1 = rowp - 1'b1;
  assign col_ok = (colp != '0) && (colp <= COLS_C);
  assign row_ok = (rowp != '0) && (rowp <= ROWS_C);
  assign ram_rd_addr = {ROW_W'(row_m1), COL_W'(col_m1)};

  // Squared distance terms per neighbor column and row; the centre tile contributes zero.
  always_comb begin
    case (ci_r)
      2'd0:    sel_dx2 = job_r.sqx_lo;
      2'd2:    sel_dx2 = job_r.sqx_hi;
      default: sel_dx2 = '0;
    endcase
    case (ri_r)
      2'd0:    sel_dy2 = job_r.sqy_lo;
      2'd2:    sel_dy2 = job_r.sqy_hi;
      default: sel_dy2 = '0;
    endcase
  end

  // Evaluation of the neighbor read in the previous cycle.
  assign ev_hit = ev_valid_r && ev_inmap_r && ram_rd_data &&
                  (ev_d2_r < ctmc_pkg::D2_W'(job_r.r2));

  assign clearing  = (state_r == ctmc_pkg::B_CLEAR);
  assign pop_ready = (state_r == ctmc_pkg::B_IDLE);
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // Sequencer for clearing, map writes and neighborhood scans.
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    clr_cnt_nxt   = clr_cnt_r;
    ci_nxt        = ci_r;
    ri_nxt        = ri_r;
    ev_valid_nxt  = 1'b0;
    ev_inmap_nxt  = ev_inmap_r;
    ev_d2_nxt     = ev_d2_r;
    hit_acc_nxt   = hit_acc_r | ev_hit;
    out_valid_nxt = out_valid_r && !out_ready;
    out_hit_nxt   = out_hit_r;
    ram_we        = 1'b0;
    ram_wr_addr   = clr_cnt_r;
    ram_wr_data   = 1'b0;
    case (state_r)
      ctmc_pkg::B_CLEAR: begin
        ram_we      = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ctmc_pkg::B_IDLE;
        end
      end
      ctmc_pkg::B_IDLE: begin
        if (pop_valid) begin
          if (pop_job.is_query) begin
            job_nxt     = pop_job;
            ci_nxt      = 2'd0;
            ri_nxt      = 2'd0;
            hit_acc_nxt = 1'b0;
            state_nxt   = ctmc_pkg::B_SCAN;
          end else begin
            ram_we      = 1'b1;
            ram_wr_addr = {ROW_W'(pop_job.tile_row), COL_W'(pop_job.tile_col)};
            ram_wr_data = pop_job.solid;
          end
        end
      end
      ctmc_pkg::B_SCAN: begin
        // One neighbor read per cycle.
        ev_valid_nxt = 1'b1;
        ev_inmap_nxt = col_ok && row_ok;
        ev_d2_nxt    = ctmc_pkg::D2_W'(sel_dx2) + ctmc_pkg::D2_W'(sel_dy2);
        if (ci_r == 2'd2) begin
          ci_nxt = 2'd0;
          ri_nxt = ri_r + 1'b1;
          if (ri_r == 2'd2) begin
            state_nxt = ctmc_pkg::B_DRAIN;
          end
        end else begin
          ci_nxt = ci_r + 1'b1;
        end
      end
      ctmc_pkg::B_DRAIN: begin
        state_nxt = ctmc_pkg::B_OUT;
      end
      ctmc_pkg::B_OUT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit_acc_r;
          state_nxt     = ctmc_pkg::B_IDLE;
        end
      end
      default: begin
        state_nxt = ctmc_pkg::B_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ctmc_pkg::B_CLEAR;
      clr_cnt_r   <= '0;
      ci_r        <= 2'd0;
      ri_r        <= 2'd0;
      ev_valid_r  <= 1'b0;
      hit_acc_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ci_r        <= ci_nxt;
      ri_r        <= ri_nxt;
      ev_valid_r  <= ev_valid_nxt;
      hit_acc_r   <= hit_acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    job_r      <= job_nxt;
    ev_inmap_r <= ev_inmap_nxt;
    ev_d2_r    <= ev_d2_nxt;
    out_hit_r  <= out_hit_nxt;
  end

`ifndef SYNTHESIS
  // The map is never written while a scan reads it.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctmc_pkg::B_SCAN) |-> !ram_we)
    else $error("map write during neighborhood scan");

  // An evaluation slot always follows a scan read.
  assert property (@(posedge clk) disable iff (!rst_n)
    ev_valid_r |-> ($past(state_r) == ctmc_pkg::B_SCAN))
    else $error("evaluation without a preceding neighbor read");

  // No job leaves the queue while the map is being cleared.
  assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !(pop_valid && pop_ready))
    else $error("job taken during clearing pass");

  // The neighbor counters stay within the 3x3 window during a scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ctmc_pkg::B_SCAN) |-> ((ci_r != 2'd3) && (ri_r != 2'd3)))
    else $error("neighbor counter out of range");

  // Leaving the output state always loads a result.
  assert property (@(posedge clk) disable iff (!rst_n)
    ($past(state_r) == ctmc_pkg::B_OUT) && (state_r == ctmc_pkg::B_IDLE) |-> out_valid_r)
    else $error("query finished without a result");
`endif

endmodule

// ===== hdl/circle_tile_map_collision_core.sv =====
// Top level of the circle tile map collision core: configuration port and channel wiring.
//
//   Channel  Port group  Direction  Carries
//   in       in_t*       slave      tile writes and collision queries
//   out      out_t*      master     one hit flag per query
//   cfg      cfg_p*      slave      radius register, address 0
//
// In the back end a query makes nine map reads through the single read port of the map RAM,
// then evaluates the last read and loads the result. The back end writes a tile from its
// idle state; the front end prepares a query in the states F_DIV, F_FIX, F_SQR and F_PUSH.
// After reset the map is cleared one tile per cycle, all MAP_ROWS * 2**clog2(MAP_COLS) tiles
// (4096 by default), and no input transaction is accepted until it is done.
// A waiting result stalls the back end; the queue keeps the front end going until it is full.
module circle_tile_map_collision_core #(
  parameter int MAP_COLS    = ctmc_pkg::MAP_COLS_DEF,
  parameter int MAP_ROWS    = ctmc_pkg::MAP_ROWS_DEF,
  parameter int TILE_PIXELS = ctmc_pkg::TILE_PIXELS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               in_tuser,   // kind
  input  logic [ctmc_pkg::IN_DATA_W-1:0]     in_tdata,   // tile_col, tile_row, tile_code,
                                                         // pos_x, pos_y
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ctmc_pkg::OUT_DATA_W-1:0]    out_tdata,  // hit, zero fill
  // Configuration port.
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [ctmc_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [ctmc_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [ctmc_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                               cfg_pready
);

  logic [ctmc_pkg::RADIUS_W-1:0] radius_r, radius_nxt;
  logic                          cfg_wr;
  logic                          clearing;
  logic                          push_valid, push_ready;
  logic                          pop_valid, pop_ready;
  ctmc_pkg::job_t                push_job, pop_job;
  logic                          out_hit;

  // Register access.
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    radius_nxt = radius_r;
    if (cfg_wr && (cfg_paddr[ctmc_pkg::CFG_ADDR_W-1:2] == ctmc_pkg::REG_RADIUS)) begin
      radius_nxt = cfg_pwdata[ctmc_pkg::RADIUS_W-1:0];
    end
    if (cfg_paddr[ctmc_pkg::CFG_ADDR_W-1:2] == ctmc_pkg::REG_RADIUS) begin
      cfg_prdata = ctmc_pkg::CFG_DATA_W'(radius_r);
    end else begin
      cfg_prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= ctmc_pkg::RADIUS_RESET;
    end else begin
      radius_r <= radius_nxt;
    end
  end

  // Front end.
  ctmc_front #(
    .MAP_COLS    (MAP_COLS),
    .MAP_ROWS    (MAP_ROWS),
    .TILE_PIXELS (TILE_PIXELS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .radius     (radius_r),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  // Job queue.
  ctmc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  // Back end.
  ctmc_back #(
    .MAP_COLS (MAP_COLS),
    .MAP_ROWS (MAP_ROWS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_hit   (out_hit)
  );

  assign out_tdata = {{(ctmc_pkg::OUT_DATA_W - 1){1'b0}}, out_hit};

endmodule

// ===== tb/tb_circle_tile_map_collision_core.sv =====
// Self-checking testbench of the circle tile map collision core.
`timescale 1ns / 1ps

module tb_circle_tile_map_collision_core;

  localparam int MAP_C         = ctmc_pkg::MAP_COLS_DEF;
  localparam int MAP_R         = ctmc_pkg::MAP_ROWS_DEF;
  localparam int TILE_Q4       = ctmc_pkg::TILE_PIXELS_DEF * 16;
  localparam int POS_MAX       = (1 << ctmc_pkg::POS_W) - 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int PHASES        = 8;
  localparam int PHASE_ITEMS   = 200;
  localparam int NO_TYPED      = -1;

  // Operations of the directed table.
  typedef enum logic [1:0] {
    ROW_TILE,
    ROW_QUERY,
    ROW_RADIUS
  } row_op_t;

  typedef struct {
    row_op_t     op;
    int unsigned col;
    int unsigned row;
    int unsigned code;
    int unsigned px;
    int unsigned py;
    int unsigned rad;
    int          typed_hit;  // NO_TYPED means the predictor decides
  } dir_row_t;

  localparam int DIR_ROWS = 29;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic                            in_tuser;   // kind
  logic [ctmc_pkg::IN_DATA_W-1:0]  in_tdata;   // tile_col, tile_row, tile_code, pos_x, pos_y
  logic                            out_tvalid;
  logic                            out_tready;
  logic [ctmc_pkg::OUT_DATA_W-1:0] out_tdata;  // hit, zero fill
  logic                            cfg_psel;
  logic                            cfg_penable;
  logic                            cfg_pwrite;
  logic [ctmc_pkg::CFG_ADDR_W-1:0] cfg_paddr;
  logic [ctmc_pkg::CFG_DATA_W-1:0] cfg_pwdata;
  logic [ctmc_pkg::CFG_DATA_W-1:0] cfg_prdata;
  logic                            cfg_pready;

  // Shadow copy of the block state.
  bit          tile_solid [0:MAP_R-1][0:MAP_C-1];
  int unsigned radius_now;
  bit          pending_hits [$];

  int          errors;
  int          n_writes;
  int          n_queries;
  int          n_hits;
  int          n_radius;
  int          burst_left;
  int          gap_max;
  dir_row_t    dir_rows [0:DIR_ROWS-1];

  circle_tile_map_collision_core DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tuser    (in_tuser),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Tile classification: '1', 'G' through 'N' and 'h' through 'n' are solid.
  function automatic bit tile_code_solid(input logic [ctmc_pkg::CODE_W-1:0] code);
    return (code == ctmc_pkg::CODE_ONE) ||
           (code >= ctmc_pkg::CODE_UC_LO && code <= ctmc_pkg::CODE_UC_HI) ||
           (code >= ctmc_pkg::CODE_LC_LO && code <= ctmc_pkg::CODE_LC_HI);
  endfunction

  // True when the circle at (px, py) overlaps a solid tile of the 3x3 neighborhood.
  function automatic bit circle_overlaps_solid(input int unsigned px, input int unsigned py);
    longint cx, cy, col, row, wx, wy, nx, ny, dx, dy, r2;
    bit     hit;
    hit = 1'b0;
    cx  = longint'(px / TILE_Q4);
    cy  = longint'(py / TILE_Q4);
    r2  = longint'(radius_now) * longint'(radius_now);
    for (int i = -1; i <= 1; i++) begin
      for (int j = -1; j <= 1; j++) begin
        col = cx + i;
        row = cy + j;
        // Cells beyond the map edge are open.
        if (col >= 0 && row >= 0 && col < MAP_C && row < MAP_R) begin
          if (tile_solid[row][col]) begin
            wx = col * TILE_Q4;
            wy = row * TILE_Q4;
            // Clamp the center into the closed tile square.
            nx = (px < wx) ? wx : ((px > wx + TILE_Q4) ? wx + TILE_Q4 : px);
            ny = (py < wy) ? wy : ((py > wy + TILE_Q4) ? wy + TILE_Q4 : py);
            dx = px - nx;
            dy = py - ny;
            if (dx * dx + dy * dy < r2) hit = 1'b1;
          end
        end
      end
    end
    return hit;
  endfunction

  // Drives one input transaction, waits for its acceptance and records the expectation.
  task automatic send_item(input logic kind, input int unsigned col, input int unsigned row,
                           input int unsigned code, input int unsigned px,
                           input int unsigned py, input int typed_hit);
    logic [ctmc_pkg::IN_DATA_W-1:0] data;
    bit                             hit;
    data = {ctmc_pkg::POS_W'(py), ctmc_pkg::POS_W'(px), ctmc_pkg::CODE_W'(code),
            ctmc_pkg::TILE_IDX_W'(row), ctmc_pkg::TILE_IDX_W'(col)};
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= data;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (kind == ctmc_pkg::KIND_WRITE) begin
      tile_solid[row % MAP_R][col % MAP_C] = tile_code_solid(ctmc_pkg::CODE_W'(code));
      n_writes++;
    end else begin
      hit = circle_overlaps_solid(px % (POS_MAX + 1), py % (POS_MAX + 1));
      if (typed_hit != NO_TYPED) hit = (typed_hit != 0);
      pending_hits.push_back(hit);
      n_queries++;
    end
    // Bursts of back-to-back transactions with random gaps between them.
    if (burst_left == 0) burst_left = $urandom_range(1, 24);
    burst_left--;
    if (burst_left == 0 && gap_max > 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, gap_max)) @(posedge clk);
    end
  endtask

  // Stops the input and waits until every result is back and the block is quiet.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_hits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register transaction: setup, access until pready, then idle.
  task automatic cfg_access(input bit wr, input logic [ctmc_pkg::CFG_DATA_W-1:0] wdata,
                            output logic [ctmc_pkg::CFG_DATA_W-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ctmc_pkg::CFG_ADDR_W'(4 * ctmc_pkg::REG_RADIUS);
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // Reads the radius back and compares it with the shadow copy.
  task automatic check_radius();
    logic [ctmc_pkg::CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, '0, rd);
    if (rd[ctmc_pkg::RADIUS_W-1:0] !== ctmc_pkg::RADIUS_W'(radius_now)) begin
      $display("%0t: radius readback mismatch, expected %0d, actual %0d",
               $time, radius_now, rd[ctmc_pkg::RADIUS_W-1:0]);
      errors++;
    end
  endtask

  // Writes a new radius while the block is idle.
  task automatic set_radius(input int unsigned value);
    logic [ctmc_pkg::CFG_DATA_W-1:0] rd;
    settle();
    cfg_access(1'b1, ctmc_pkg::CFG_DATA_W'(value), rd);
    radius_now = value;
    n_radius++;
    check_radius();
  endtask

  // Receiver: stall pattern that switches between random modes.
  initial begin
    int mode;
    int span;
    out_tready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 200);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0: begin
            out_tready <= 1'b1;
          end
          1: begin
            out_tready <= 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready <= ($urandom_range(0, 7) != 0);
          end
          default: begin
            out_tready <= ($urandom_range(0, 7) == 0);
          end
        endcase
      end
    end
  end

  // Result checker: each result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_hits.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %0d", $time, out_tdata[0]);
        errors++;
      end else begin
        if (out_tdata[0] !== pending_hits[0]) begin
          $display("%0t: hit mismatch, expected %0d, actual %0d",
                   $time, pending_hits[0], out_tdata[0]);
          errors++;
        end
        if (out_tdata[0] === 1'b1) n_hits++;
        void'(pending_hits.pop_front());
      end
    end
  end

  // Stimulus.
  initial begin
    int unsigned wc, wr, col, row, code, px, py;
    int          t;
    bit          kind;

    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= ctmc_pkg::KIND_WRITE;
    in_tdata    <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    errors      = 0;
    n_writes    = 0;
    n_queries   = 0;
    n_hits      = 0;
    n_radius    = 0;
    burst_left  = 0;
    gap_max     = 4;
    radius_now  = 32'(ctmc_pkg::RADIUS_RESET);
    foreach (tile_solid[r, c]) tile_solid[r][c] = 1'b0;

    // Directed rows: op, col, row, code, px, py, radius, typed hit.
    dir_rows = '{
      '{ROW_QUERY,  0,  0, 0,     0,     0,    0, 0},         // empty map after reset
      '{ROW_QUERY,  0,  0, 0, 16383, 16383,    0, 0},
      '{ROW_TILE,   0,  0, 'h31,   0,     0,    0, NO_TYPED},  // '1'
      '{ROW_QUERY,  0,  0, 0,     0,     0,    0, 1},         // center inside a solid tile
      '{ROW_TILE,  63, 63, 'h47,   0,     0,    0, NO_TYPED},  // 'G'
      '{ROW_QUERY,  0,  0, 0, 16383, 16383,    0, 1},
      '{ROW_TILE,  10, 10, 'h46,   0,     0,    0, NO_TYPED},  // 'F' is open
      '{ROW_QUERY,  0,  0, 0,  2688,  2688,    0, 0},
      '{ROW_TILE,  10, 10, 'h4E,   0,     0,    0, NO_TYPED},  // 'N'
      '{ROW_QUERY,  0,  0, 0,  2688,  2688,    0, 1},
      '{ROW_TILE,  10, 10, 'h4F,   0,     0,    0, NO_TYPED},  // 'O' is open
      '{ROW_QUERY,  0,  0, 0,  2688,  2688,    0, 0},
      '{ROW_TILE,  10, 10, 'h68,   0,     0,    0, NO_TYPED},  // 'h'
      '{ROW_QUERY,  0,  0, 0,  2688,  2688,    0, 1},
      '{ROW_TILE,  20,  5, 'h67,   0,     0,    0, NO_TYPED},  // 'g' is open
      '{ROW_TILE,  10, 10, 'h6E,   0,     0,    0, NO_TYPED},  // 'n'
      // Touching the far edge of the tile counts; a distance equal to the radius does not.
      '{ROW_QUERY,  0,  0, 0,  2816,  2688,    0, NO_TYPED},
      '{ROW_QUERY,  0,  0, 0,  2976,  2688,    0, NO_TYPED},
      '{ROW_QUERY,  0,  0, 0,  2975,  2688,    0, NO_TYPED},
      '{ROW_RADIUS, 0,  0, 0,     0,     0,    0, NO_TYPED},
      '{ROW_QUERY,  0,  0, 0,  2688,  2688,    0, 0},         // zero radius never hits
      '{ROW_RADIUS, 0,  0, 0,     0,     0, 1023, NO_TYPED},
      '{ROW_QUERY, 63, 63, 'hFF, 300,   300,    0, NO_TYPED},  // tile fields of a query are ignored
      '{ROW_QUERY,  0,  0, 0, 16383,     0,    0, NO_TYPED},
      '{ROW_TILE,   0,  0, 'hFF,   0,     0,    0, NO_TYPED},
      '{ROW_TILE,  63,  0, 'h00, 16383, 16383,  0, NO_TYPED},
      '{ROW_QUERY,  0,  0, 0,     0,     0,    0, 0},         // far from every solid tile
      '{ROW_QUERY,  0,  0, 0, 16383, 16383,    0, 1},
      '{ROW_RADIUS, 0,  0, 0,     0,     0,  160, NO_TYPED}
    };

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_radius();

    // Directed part.
    foreach (dir_rows[i]) begin
      case (dir_rows[i].op)
        ROW_RADIUS: begin
          set_radius(dir_rows[i].rad);
        end
        ROW_TILE: begin
          send_item(ctmc_pkg::KIND_WRITE, dir_rows[i].col, dir_rows[i].row, dir_rows[i].code,
                    dir_rows[i].px, dir_rows[i].py, NO_TYPED);
        end
        default: begin
          send_item(ctmc_pkg::KIND_QUERY, dir_rows[i].col, dir_rows[i].row, dir_rows[i].code,
                    dir_rows[i].px, dir_rows[i].py, dir_rows[i].typed_hit);
        end
      endcase
    end

    // Random part: one radius per phase, writes and queries clustered in a moving window.
    wc = 0;
    wr = 0;
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       set_radius(1023);
        1:       set_radius(1);
        2:       set_radius(0);
        default: set_radius($urandom_range(2, 400));
      endcase
      gap_max = (ph % 3 == 1) ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k % 40 == 0) begin
          // Edge windows reach the map border from both sides.
          case ($urandom_range(0, 3))
            0: begin
              wc = 0;
              wr = $urandom_range(0, MAP_R - 8);
            end
            1: begin
              wc = MAP_C - 8;
              wr = MAP_R - 8;
            end
            default: begin
              wc = $urandom_range(0, MAP_C - 8);
              wr = $urandom_range(0, MAP_R - 8);
            end
          endcase
        end
        kind = ($urandom_range(0, 99) < 45) ? ctmc_pkg::KIND_WRITE : ctmc_pkg::KIND_QUERY;
        col  = $urandom_range(0, MAP_C - 1);
        row  = $urandom_range(0, MAP_R - 1);
        code = $urandom_range(0, 255);
        px   = $urandom_range(0, POS_MAX);
        py   = $urandom_range(0, POS_MAX);
        if (kind == ctmc_pkg::KIND_WRITE) begin
          if ($urandom_range(0, 9) < 7) begin
            col = wc + $urandom_range(0, 7);
            row = wr + $urandom_range(0, 7);
          end
          if ($urandom_range(0, 9) < 5) begin
            case ($urandom_range(0, 2))
              0:       code = 32'(ctmc_pkg::CODE_ONE);
              1:       code = ctmc_pkg::CODE_UC_LO + $urandom_range(0, 7);
              default: code = ctmc_pkg::CODE_LC_LO + $urandom_range(0, 6);
            endcase
          end
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2: begin
              // Anywhere in the map.
            end
            3, 4: begin
              // Near tile corners and edges.
              t  = (wc + $urandom_range(0, 8)) * TILE_Q4 + $urandom_range(0, 2) - 1;
              px = (t < 0) ? 0 : ((t > POS_MAX) ? POS_MAX : t);
              t  = (wr + $urandom_range(0, 8)) * TILE_Q4 + $urandom_range(0, 2) - 1;
              py = (t < 0) ? 0 : ((t > POS_MAX) ? POS_MAX : t);
            end
            default: begin
              px = wc * TILE_Q4 + $urandom_range(0, 8 * TILE_Q4 - 1);
              py = wr * TILE_Q4 + $urandom_range(0, 8 * TILE_Q4 - 1);
            end
          endcase
        end
        send_item(kind, col, row, code, px, py, NO_TYPED);
      end
    end

    // Drain and report.
    settle();
    $display("Covered %0d tile writes and %0d queries, %0d of them hits,", n_writes,
             n_queries, n_hits);
    $display("across %0d radius settings with random input gaps and output stalls.",
             n_radius);
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/ctmc_pkg.sv
hdl/ctmc_ram.sv
hdl/ctmc_front.sv
hdl/ctmc_queue.sv
hdl/ctmc_back.sv
hdl/circle_tile_map_collision_core.sv
tb/tb_circle_tile_map_collision_core.sv
